// ===== rtl/bprl_pkg.sv =====
// ----------------------------------------------------------------------------
// bprl_pkg
// Types and constants shared by the BSP point region locator.
// ----------------------------------------------------------------------------
package bprl_pkg;

    localparam int MAX_NODES = 256;
    localparam int FRAC_BITS = 12;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int LINK_W    = ADDR_W + 1;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CRD_W     = 24;
    localparam int RGN_W     = 16;
    localparam int OFF_W     = 50;
    localparam int PROD_W    = 2 * CRD_W;
    localparam int ACC_W     = OFF_W + 1;

    typedef enum logic [1:0] {
        OP_QUERY   = 2'd0,
        OP_ADD_POS = 2'd1,
        OP_ADD_NEG = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [LINK_W-1:0] LINK_NONE = '1;
    localparam logic [RGN_W-1:0]  RGN_NONE  = '1;

    typedef struct packed {
        logic signed [CRD_W-1:0] nx;
        logic signed [CRD_W-1:0] ny;
        logic signed [OFF_W-1:0] off;
        logic [LINK_W-1:0]       par;
        logic [LINK_W-1:0]       pc;
        logic [LINK_W-1:0]       nc;
        logic [RGN_W-1:0]        pr;
        logic [RGN_W-1:0]        nr;
    } node_t;

    localparam node_t ROOT_NODE = '{
        nx:  CRD_W'(1) <<< FRAC_BITS,
        ny:  '0,
        off: '0,
        par: LINK_NONE,
        pc:  LINK_NONE,
        nc:  LINK_NONE,
        pr:  RGN_NONE,
        nr:  RGN_NONE
    };

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
    } mac_ctl_t;

endpackage

// ===== rtl/bprl_node_mem.sv =====
// ----------------------------------------------------------------------------
// bprl_node_mem
// Node table: one write port, one registered read port, root defaults.
// ----------------------------------------------------------------------------
module bprl_node_mem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [bprl_pkg::ADDR_W-1:0] rd_addr,
    output bprl_pkg::node_t       rd_data,
    input  logic                  wr_en,
    input  logic [bprl_pkg::ADDR_W-1:0] wr_addr,
    input  bprl_pkg::node_t       wr_data
);
    import bprl_pkg::*;

    node_t mem [MAX_NODES];
    node_t rd_q;
    logic  dflt_q;
    logic  root_wr_reg;

    // root reads as its reset contents until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_wr_reg <= 1'b0;
        else if (wr_en && wr_addr == '0)
            root_wr_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_q   <= mem[rd_addr];
            dflt_q <= (rd_addr == '0) && !root_wr_reg;
        end
    end

    assign rd_data = dflt_q ? ROOT_NODE : rd_q;

endmodule

// ===== rtl/bprl_mac.sv =====
// ----------------------------------------------------------------------------
// bprl_mac
// Shared multiply-accumulate unit with a registered product.
// ----------------------------------------------------------------------------
module bprl_mac (
    input  logic                               clk,
    input  bprl_pkg::mac_ctl_t                 ctl,
    input  logic signed [bprl_pkg::CRD_W-1:0]  a,
    input  logic signed [bprl_pkg::CRD_W-1:0]  b,
    input  logic signed [bprl_pkg::ACC_W-1:0]  init,
    output logic signed [bprl_pkg::ACC_W-1:0]  acc
);
    import bprl_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
            prod_reg <= a * b;
        if (ctl.load)
            acc_reg <= init;
        else if (ctl.acc)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/bsp_point_region_locator_top.sv =====
// ----------------------------------------------------------------------------
// bsp_point_region_locator_top
// 2D BSP point location with add and subtree removal over a node table.
// ----------------------------------------------------------------------------
// query: per tree level visited, one node read, two mac steps, an accumulate, a check
// add: two mac steps, then node and parent writes; removal: mark and compaction
// passes over the single node table read port; errors go straight to the result
// one item at a time: in_stall is high from accept until the result is queued
// reset: one root node with normal (1,0), offset 0; output register empty
// ----------------------------------------------------------------------------
module bsp_point_region_locator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [7:0]                         node_index,
    input  logic signed [15:0]                 region_id,
    input  logic signed [23:0]                 coord_x,
    input  logic signed [23:0]                 coord_y,
    input  logic signed [23:0]                 dir_x,
    input  logic signed [23:0]                 dir_y,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         result_node,
    output logic signed [15:0]                 result_region,
    output logic [8:0]                         node_total,
    output logic [1:0]                         status
);
    import bprl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_Q_RD, S_Q_M1, S_Q_M2, S_Q_M3, S_Q_G,
        S_ADD_M1, S_ADD_M2, S_ADD_M3, S_ADD_WN, S_ADD_WP,
        S_A_RD, S_A_PAR, S_A_WR,
        S_B_RD, S_B_CHK, S_B_L1, S_B_L2, S_B_L3,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next, k_reg, k_next;
    logic [RGN_W-1:0]        rid_reg, rid_next;
    logic signed [CRD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CRD_W-1:0] dy_reg, dy_next, ny_reg, ny_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next, i_reg, i_next;
    logic [CNT_W-1:0]        n_reg, n_next, w_reg, w_next;
    logic                    vic_reg, vic_next, need_reg, need_next;
    logic [LINK_W-1:0]       par_reg, par_next, pc_reg, pc_next;
    logic [ADDR_W-1:0]       rnode_reg, rnode_next;
    logic [RGN_W-1:0]        rrgn_reg, rrgn_next;
    logic [1:0]              st_reg, st_next;
    logic                    ov_reg, ov_next;
    logic [ADDR_W-1:0]       ores_node_reg, ores_node_next;
    logic [RGN_W-1:0]        ores_rgn_reg, ores_rgn_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;
    logic [1:0]              ost_reg, ost_next;

    // node table
    logic              nm_rd_en, nm_wr_en;
    logic [ADDR_W-1:0] nm_rd_addr, nm_wr_addr;
    node_t             node_q, nm_wr_data;

    // removal scratch memories
    logic              mark_mem [MAX_NODES];
    logic [LINK_W-1:0] remap_mem [MAX_NODES];
    logic              mk_rd_en, mk_we, mk_wd, mark_q;
    logic [ADDR_W-1:0] mk_ra, mk_wa;
    logic              rm_rd_en, rm_we;
    logic [ADDR_W-1:0] rm_ra, rm_wa;
    logic [LINK_W-1:0] rm_wd, remap_q;

    mac_ctl_t                mac_ctl;
    logic signed [CRD_W-1:0] mac_a, mac_b;
    logic signed [ACC_W-1:0] mac_init, mac_acc;

    logic              g_pos, g_nneg, mark_now;
    logic [LINK_W-1:0] nxt, link_new;
    node_t             upd;

    bprl_node_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (nm_rd_en),
        .rd_addr (nm_rd_addr),
        .rd_data (node_q),
        .wr_en   (nm_wr_en),
        .wr_addr (nm_wr_addr),
        .wr_data (nm_wr_data)
    );

    bprl_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .a    (mac_a),
        .b    (mac_b),
        .init (mac_init),
        .acc  (mac_acc)
    );

    always_ff @(posedge clk)
    begin
        if (mk_we)
            mark_mem[mk_wa] <= mk_wd;
        if (mk_rd_en)
            mark_q <= mark_mem[mk_ra];
        if (rm_we)
            remap_mem[rm_wa] <= rm_wd;
        if (rm_rd_en)
            remap_q <= remap_mem[rm_ra];
    end

    assign g_pos    = !mac_acc[ACC_W-1] && (mac_acc != '0);
    assign g_nneg   = !mac_acc[ACC_W-1];
    assign nxt      = g_pos ? node_q.pc : node_q.nc;
    assign mark_now = vic_reg | (need_reg & mark_q);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;       idx_next = idx_reg;   k_next = k_reg;
        rid_next = rid_reg;     cx_next = cx_reg;     cy_next = cy_reg;
        dy_next = dy_reg;       ny_next = ny_reg;     cnt_next = cnt_reg;
        i_next = i_reg;         n_next = n_reg;       w_next = w_reg;
        vic_next = vic_reg;     need_next = need_reg;
        par_next = par_reg;     pc_next = pc_reg;
        rnode_next = rnode_reg; rrgn_next = rrgn_reg; st_next = st_reg;
        ov_next = ov_reg;       ores_node_next = ores_node_reg;
        ores_rgn_next = ores_rgn_reg;
        ocnt_next = ocnt_reg;   ost_next = ost_reg;

        nm_rd_en = 1'b0; nm_rd_addr = '0;
        nm_wr_en = 1'b0; nm_wr_addr = '0; nm_wr_data = node_q;
        mk_rd_en = 1'b0; mk_ra = '0; mk_we = 1'b0; mk_wa = '0; mk_wd = 1'b0;
        rm_rd_en = 1'b0; rm_ra = '0; rm_we = 1'b0; rm_wa = '0; rm_wd = '0;
        mac_ctl = '0; mac_a = cx_reg; mac_b = dy_reg; mac_init = '0;
        link_new = LINK_NONE;
        upd = node_q;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = op_t'(operation);
                    idx_next = node_index;
                    rid_next = region_id;
                    cx_next  = coord_x;
                    cy_next  = coord_y;
                    dy_next  = dir_y;
                    // negating the most negative x saturates
                    ny_next  = (dir_x == {1'b1, {(CRD_W-1){1'b0}}}) ?
                               {1'b0, {(CRD_W-1){1'b1}}} : -dir_x;
                    k_next   = '0;
                    i_next   = '0;
                    n_next   = '0;
                    w_next   = '0;
                    rnode_next = '0;
                    rrgn_next  = RGN_NONE;
                    st_next    = ST_OK;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (op_reg)
                    OP_QUERY:
                        state_next = S_Q_RD;
                    OP_ADD_POS, OP_ADD_NEG:
                    begin
                        if ({1'b0, idx_reg} >= cnt_reg)
                        begin
                            st_next = ST_BAD;
                            state_next = S_DONE;
                        end
                        else if (cnt_reg >= CNT_W'(MAX_NODES))
                        begin
                            st_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_ADD_M1;
                    end
                    default:
                    begin
                        if (idx_reg == '0 || {1'b0, idx_reg} >= cnt_reg)
                        begin
                            st_next = ST_BAD;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_A_RD;
                    end
                endcase
            end
            S_Q_RD:
            begin
                nm_rd_en = 1'b1;
                nm_rd_addr = k_reg;
                state_next = S_Q_M1;
            end
            S_Q_M1:
            begin
                mac_ctl.load = 1'b1;
                mac_ctl.mul = 1'b1;
                mac_init = ACC_W'(node_q.off);
                mac_a = node_q.nx;
                mac_b = cx_reg;
                state_next = S_Q_M2;
            end
            S_Q_M2:
            begin
                mac_ctl.mul = 1'b1;
                mac_ctl.acc = 1'b1;
                mac_a = node_q.ny;
                mac_b = cy_reg;
                state_next = S_Q_M3;
            end
            S_Q_M3:
            begin
                mac_ctl.acc = 1'b1;
                state_next = S_Q_G;
            end
            S_Q_G:
            begin
                // child links always point forward, so descent ends
                if (nxt[LINK_W-1] || {1'b0, nxt[ADDR_W-1:0]} >= cnt_reg)
                begin
                    rnode_next = k_reg;
                    if (k_reg != '0)
                        rrgn_next = g_nneg ? node_q.pr : node_q.nr;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = nxt[ADDR_W-1:0];
                    state_next = S_Q_RD;
                end
            end
            S_ADD_M1:
            begin
                mac_ctl.load = 1'b1;
                mac_ctl.mul = 1'b1;
                mac_a = cx_reg;
                mac_b = dy_reg;
                state_next = S_ADD_M2;
            end
            S_ADD_M2:
            begin
                mac_ctl.mul = 1'b1;
                mac_ctl.acc = 1'b1;
                mac_a = cy_reg;
                mac_b = ny_reg;
                state_next = S_ADD_M3;
            end
            S_ADD_M3:
            begin
                mac_ctl.acc = 1'b1;
                nm_rd_en = 1'b1;
                nm_rd_addr = idx_reg;
                state_next = S_ADD_WN;
            end
            S_ADD_WN:
            begin
                nm_wr_en = 1'b1;
                nm_wr_addr = cnt_reg[ADDR_W-1:0];
                nm_wr_data.nx  = dy_reg;
                nm_wr_data.ny  = ny_reg;
                nm_wr_data.off = OFF_W'(-mac_acc);
                nm_wr_data.par = {1'b0, idx_reg};
                nm_wr_data.pc  = LINK_NONE;
                nm_wr_data.nc  = LINK_NONE;
                nm_wr_data.pr  = RGN_NONE;
                nm_wr_data.nr  = RGN_NONE;
                state_next = S_ADD_WP;
            end
            S_ADD_WP:
            begin
                if (op_reg == OP_ADD_POS)
                begin
                    upd.pc = {1'b0, cnt_reg[ADDR_W-1:0]};
                    upd.pr = rid_reg;
                end
                else
                begin
                    upd.nc = {1'b0, cnt_reg[ADDR_W-1:0]};
                    upd.nr = rid_reg;
                end
                nm_wr_en = 1'b1;
                nm_wr_addr = idx_reg;
                nm_wr_data = upd;
                rnode_next = cnt_reg[ADDR_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                state_next = S_DONE;
            end
            // mark pass: a node is removed if it is the victim or its parent is
            S_A_RD:
            begin
                nm_rd_en = 1'b1;
                nm_rd_addr = i_reg[ADDR_W-1:0];
                state_next = S_A_PAR;
            end
            S_A_PAR:
            begin
                vic_next  = (i_reg[ADDR_W-1:0] == idx_reg);
                need_next = (i_reg[ADDR_W-1:0] > idx_reg) && !node_q.par[LINK_W-1] &&
                            (node_q.par[ADDR_W-1:0] >= idx_reg);
                mk_rd_en = 1'b1;
                mk_ra = node_q.par[ADDR_W-1:0];
                state_next = S_A_WR;
            end
            S_A_WR:
            begin
                mk_we = 1'b1;
                mk_wa = i_reg[ADDR_W-1:0];
                mk_wd = mark_now;
                rm_we = 1'b1;
                rm_wa = i_reg[ADDR_W-1:0];
                rm_wd = mark_now ? LINK_NONE : n_reg;
                if (!mark_now)
                    n_next = n_reg + 1'b1;
                if (i_reg + 1'b1 == cnt_reg)
                begin
                    i_next = '0;
                    state_next = S_B_RD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end
            // compaction pass with link remapping
            S_B_RD:
            begin
                nm_rd_en = 1'b1;
                nm_rd_addr = i_reg[ADDR_W-1:0];
                mk_rd_en = 1'b1;
                mk_ra = i_reg[ADDR_W-1:0];
                state_next = S_B_CHK;
            end
            S_B_CHK:
            begin
                if (mark_q)
                begin
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == cnt_reg)
                    begin
                        cnt_next = w_reg;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_B_RD;
                end
                else
                begin
                    rm_rd_en = 1'b1;
                    rm_ra = node_q.par[ADDR_W-1:0];
                    state_next = S_B_L1;
                end
            end
            S_B_L1:
            begin
                par_next = node_q.par[LINK_W-1] ? node_q.par : remap_q;
                rm_rd_en = 1'b1;
                rm_ra = node_q.pc[ADDR_W-1:0];
                state_next = S_B_L2;
            end
            S_B_L2:
            begin
                pc_next = node_q.pc[LINK_W-1] ? node_q.pc : remap_q;
                rm_rd_en = 1'b1;
                rm_ra = node_q.nc[ADDR_W-1:0];
                state_next = S_B_L3;
            end
            S_B_L3:
            begin
                link_new = node_q.nc[LINK_W-1] ? node_q.nc : remap_q;
                upd.par = par_reg;
                upd.pc  = pc_reg;
                upd.nc  = link_new;
                nm_wr_en = 1'b1;
                nm_wr_addr = w_reg[ADDR_W-1:0];
                nm_wr_data = upd;
                w_next = w_reg + 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == cnt_reg)
                begin
                    cnt_next = w_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_B_RD;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    ores_node_next = rnode_reg;
                    ores_rgn_next  = rrgn_reg;
                    ocnt_next = cnt_reg;
                    ost_next  = st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_QUERY;   idx_reg <= '0;  k_reg <= '0;
            rid_reg <= '0;        cx_reg <= '0;   cy_reg <= '0;
            dy_reg <= '0;         ny_reg <= '0;
            cnt_reg <= CNT_W'(1); i_reg <= '0;    n_reg <= '0;  w_reg <= '0;
            vic_reg <= 1'b0;      need_reg <= 1'b0;
            par_reg <= '0;        pc_reg <= '0;
            rnode_reg <= '0;      rrgn_reg <= '0; st_reg <= ST_OK;
            ov_reg <= 1'b0;       ores_node_reg <= '0; ores_rgn_reg <= '0;
            ocnt_reg <= '0;       ost_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;    idx_reg <= idx_next; k_reg <= k_next;
            rid_reg <= rid_next;  cx_reg <= cx_next;   cy_reg <= cy_next;
            dy_reg <= dy_next;    ny_reg <= ny_next;
            cnt_reg <= cnt_next;  i_reg <= i_next;     n_reg <= n_next;
            w_reg <= w_next;
            vic_reg <= vic_next;  need_reg <= need_next;
            par_reg <= par_next;  pc_reg <= pc_next;
            rnode_reg <= rnode_next; rrgn_reg <= rrgn_next; st_reg <= st_next;
            ov_reg <= ov_next;    ores_node_reg <= ores_node_next;
            ores_rgn_reg <= ores_rgn_next;
            ocnt_reg <= ocnt_next; ost_reg <= ost_next;
        end
    end

    assign out_valid     = ov_reg;
    assign result_node   = ores_node_reg;
    assign result_region = ores_rgn_reg;
    assign node_total    = ocnt_reg;
    assign status        = ost_reg;

endmodule

// ===== dv/bprl_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bprl_checker
// Watches both channels of the bsp point region locator, keeps its own copy of
// the node table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module bprl_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [7:0]          node_index,
    input  logic signed [15:0]  region_id,
    input  logic signed [23:0]  coord_x,
    input  logic signed [23:0]  coord_y,
    input  logic signed [23:0]  dir_x,
    input  logic signed [23:0]  dir_y,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [7:0]          result_node,
    input  logic signed [15:0]  result_region,
    input  logic [8:0]          node_total,
    input  logic [1:0]          status,
    output int                  fail_count,
    output int                  pending
);
    import bprl_pkg::*;

    typedef struct packed {
        logic [7:0]         rnode;
        logic signed [15:0] rregion;
        logic [8:0]         total;
        logic [1:0]         st;
    } locate_result_t;

    locate_result_t result_queue[$];

    int               tbl_count;
    logic signed [23:0] tbl_nx [MAX_NODES];
    logic signed [23:0] tbl_ny [MAX_NODES];
    logic signed [49:0] tbl_off[MAX_NODES];
    int               tbl_par[MAX_NODES];
    int               tbl_pc [MAX_NODES];
    int               tbl_nc [MAX_NODES];
    logic signed [15:0] tbl_pr [MAX_NODES];
    logic signed [15:0] tbl_nr [MAX_NODES];

    function automatic logic signed [63:0] side_of(int k, logic signed [23:0] x,
                                                  logic signed [23:0] y);
        logic signed [63:0] acc;
        acc = 64'(tbl_nx[k]) * 64'(x) + 64'(tbl_ny[k]) * 64'(y) + 64'(tbl_off[k]);
        return acc;
    endfunction

    task automatic prune_subtree(int victim);
        bit   gone[MAX_NODES];
        int   newpos[MAX_NODES];
        int   n;
        int   w;
        n = 0;
        w = 0;
        foreach (gone[i]) gone[i] = 0;
        gone[victim] = 1;
        // parents always precede children, one forward pass is enough
        for (int i = 1; i < tbl_count; i++)
            if (tbl_par[i] >= 0 && gone[tbl_par[i]]) gone[i] = 1;
        for (int i = 0; i < tbl_count; i++)
        begin
            newpos[i] = gone[i] ? -1 : n;
            if (!gone[i]) n++;
        end
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_par[i] >= 0) tbl_par[i] = newpos[tbl_par[i]];
            if (tbl_pc[i] >= 0) tbl_pc[i] = newpos[tbl_pc[i]];
            if (tbl_nc[i] >= 0) tbl_nc[i] = newpos[tbl_nc[i]];
        end
        for (int i = 0; i < tbl_count; i++)
        begin
            if (!gone[i])
            begin
                tbl_nx[w] = tbl_nx[i];  tbl_ny[w] = tbl_ny[i];
                tbl_off[w] = tbl_off[i]; tbl_par[w] = tbl_par[i];
                tbl_pc[w] = tbl_pc[i];  tbl_nc[w] = tbl_nc[i];
                tbl_pr[w] = tbl_pr[i];  tbl_nr[w] = tbl_nr[i];
                w++;
            end
        end
        tbl_count = w;
    endtask

    task automatic predict_locate();
        locate_result_t     r;
        int                 k;
        int                 nxt;
        int                 nw;
        logic signed [63:0] g;
        logic signed [63:0] nyw;
        r = '{rnode: 8'd0, rregion: -16'sd1, total: 9'd0, st: ST_OK};
        if (operation == OP_QUERY)
        begin
            k = 0;
            for (int s = 0; s < MAX_NODES; s++)
            begin
                g = side_of(k, coord_x, coord_y);
                nxt = (g > 0) ? tbl_pc[k] : tbl_nc[k];
                if (nxt < 0 || nxt >= tbl_count) break;
                k = nxt;
            end
            g = side_of(k, coord_x, coord_y);
            r.rnode = 8'(k);
            if (k > 0) r.rregion = (g >= 0) ? tbl_pr[k] : tbl_nr[k];
        end
        else if (operation == OP_ADD_POS || operation == OP_ADD_NEG)
        begin
            if (node_index >= tbl_count) r.st = ST_BAD;
            else if (tbl_count >= MAX_NODES) r.st = ST_FULL;
            else
            begin
                nw = tbl_count;
                nyw = -64'(dir_x);
                if (nyw > 64'sd8388607) nyw = 64'sd8388607;
                tbl_nx[nw] = dir_y;
                tbl_ny[nw] = 24'(nyw);
                tbl_off[nw] = 50'(-(64'(coord_x) * 64'(dir_y) + 64'(coord_y) * nyw));
                tbl_par[nw] = node_index;
                tbl_pc[nw] = -1; tbl_nc[nw] = -1;
                tbl_pr[nw] = -16'sd1; tbl_nr[nw] = -16'sd1;
                if (operation == OP_ADD_POS)
                begin
                    tbl_pc[node_index] = nw; tbl_pr[node_index] = region_id;
                end
                else
                begin
                    tbl_nc[node_index] = nw; tbl_nr[node_index] = region_id;
                end
                tbl_count = nw + 1;
                r.rnode = 8'(nw);
            end
        end
        else
        begin
            if (node_index == 0 || node_index >= tbl_count) r.st = ST_BAD;
            else prune_subtree(node_index);
        end
        r.total = 9'(tbl_count);
        result_queue.push_back(r);
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        tbl_count = 1;
        tbl_nx[0] = 24'sd1 <<< FRAC_BITS; tbl_ny[0] = '0; tbl_off[0] = '0;
        tbl_par[0] = -1; tbl_pc[0] = -1; tbl_nc[0] = -1;
        tbl_pr[0] = -16'sd1; tbl_nr[0] = -16'sd1;
    end

    always @(posedge clk)
    begin
        locate_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall) predict_locate();
            if (out_valid && !out_stall)
            begin
                if (result_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result item node %0d", result_node);
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (want.rnode !== result_node || want.rregion !== result_region ||
                        want.total !== node_total || want.st !== status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch exp node %0d rgn %0d tot %0d st %0d,",
                                      " got %0d %0d %0d %0d"},
                                     want.rnode, want.rregion, want.total, want.st,
                                     result_node, result_region, node_total, status);
                    end
                end
            end
            pending = result_queue.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tree building, queries and subtree removals into the bsp point
// region locator with random gaps and stalls; the checker gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bprl_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         operation;
    logic [7:0]         node_index;
    logic signed [15:0] region_id;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] dir_x;
    logic signed [23:0] dir_y;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         result_node;
    logic signed [15:0] result_region;
    logic [8:0]         node_total;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;

    bsp_point_region_locator_top i_dut (.*);

    bprl_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [23:0] rand_crd();
        case ($urandom_range(0, 5))
            0: return 24'sh800000;
            1: return 24'sh7fffff;
            2: return 24'sd0;
            3: return 24'(int'($urandom_range(0, 8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    // one item; node count tracked loosely so most indexes are in range
    task automatic send_item(logic [1:0] op, logic [7:0] idx, logic signed [15:0] rid,
                             logic signed [23:0] cx, logic signed [23:0] cy,
                             logic signed [23:0] dx, logic signed [23:0] dy);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        node_index <= idx;
        region_id  <= rid;
        coord_x    <= cx;
        coord_y    <= cy;
        dir_x      <= dx;
        dir_y      <= dy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic rand_item(int n_items);
        int r;
        logic [1:0] op;
        logic [7:0] idx;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40) op = OP_QUERY;
            else if (r < 80) op = (r < 60) ? OP_ADD_POS : OP_ADD_NEG;
            else op = OP_REMOVE;
            if ($urandom_range(0, 9) == 0) idx = 8'($urandom);
            else idx = 8'($urandom_range(0, (i_checker.tbl_count > 0) ?
                                            i_checker.tbl_count - 1 : 0));
            send_item(op, idx,
                      ($urandom_range(0, 7) == 0) ? -16'sd1 : 16'($urandom),
                      rand_crd(), rand_crd(), rand_crd(), rand_crd());
        end
    endtask

    initial
    begin
        rst_n = 0; in_valid = 0; operation = OP_QUERY; node_index = 0; region_id = 0;
        coord_x = 0; coord_y = 0; dir_x = 0; dir_y = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty tree, extremes, errors, saturating normal
        send_item(OP_QUERY, 0, 0, 24'sh7fffff, 24'sh800000, 0, 0);
        send_item(OP_REMOVE, 0, 0, 0, 0, 0, 0);
        send_item(OP_REMOVE, 8'hff, 0, 0, 0, 0, 0);
        send_item(OP_ADD_POS, 8'hff, 16'sd5, 0, 0, 0, 0);
        send_item(OP_ADD_POS, 0, 16'sh7fff, 0, 0, 24'sh800000, 24'sh7fffff);
        send_item(OP_ADD_NEG, 0, -16'sd1, 24'sd4096, 24'sh800000, 24'sd4096, 0);
        send_item(OP_ADD_NEG, 1, 16'sd3, 24'sh7fffff, 24'sh7fffff, 0, 24'sh800000);
        send_item(OP_ADD_POS, 1, 16'sd4, 24'sh800000, 0, 24'sh7fffff, 24'sd0);
        send_item(OP_QUERY, 0, 0, 24'sd4096, 24'sd0, 0, 0);
        send_item(OP_QUERY, 0, 0, 24'sd0, 24'sd0, 0, 0);
        send_item(OP_QUERY, 0, 0, 24'sh800000, 24'sh7fffff, 0, 0);
        send_item(OP_QUERY, 0, 0, -24'sd8192, 24'sd100, 0, 0);
        send_item(OP_ADD_POS, 1, 16'sd9, 24'sd1, 24'sd1, 24'sd1, 24'sd1);
        send_item(OP_QUERY, 0, 0, 24'sd5, -24'sd5, 0, 0);
        send_item(OP_REMOVE, 1, 0, 0, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 24'sd5, -24'sd5, 0, 0);
        // fill the table to see full status
        for (int i = 0; i < 258; i++)
            send_item(OP_ADD_POS, 8'($urandom_range(0, i_checker.tbl_count - 1)),
                      16'($urandom), rand_crd(), rand_crd(), rand_crd(), rand_crd());
        send_item(OP_QUERY, 0, 0, rand_crd(), rand_crd(), 0, 0);
        send_item(OP_REMOVE, 1, 0, 0, 0, 0, 0);
        rand_item(474);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (fail_count == 0)
            $display("bsp_point_region_locator_top regression: pass");
        else
            $display("bsp_point_region_locator_top regression: fail");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int g;
        out_stall = 1'b0;
        wait (rst_n);
        repeat (200) @(posedge clk);
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        forever
        begin
            g = gap_len();
            out_stall <= (g != 0);
            repeat (g == 0 ? $urandom_range(1, 20) : g) @(posedge clk);
        end
    end

    initial
    begin
        #20000000;
        $display("bsp_point_region_locator_top regression: fail");
        $finish;
    end

endmodule
